// File: src/dlsq_pkg.sv
`default_nettype none
package dlsq_pkg;

  localparam int MAX_SLEEPERS = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int IDX_W        = $clog2(MAX_SLEEPERS);
  localparam int CNT_W        = $clog2(MAX_SLEEPERS + 1);
  localparam int WAKE_W       = $clog2(MAX_RESULTS + 1);
  localparam int ENTRY_W      = 40;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SLEEP  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_ACCEPTED     = 3'd0,
    KIND_BAD_DURATION = 3'd1,
    KIND_FULL         = 3'd2,
    KIND_REMOVED      = 3'd3,
    KIND_NOT_FOUND    = 3'd4,
    KIND_WOKEN        = 3'd5
  } kind_t;

  typedef struct packed {
    logic [7:0]  thread;
    logic [31:0] delta;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_RD,
    ST_S_EV,
    ST_U_RD,
    ST_U_EV,
    ST_INS,
    ST_C_RD,
    ST_C_EV,
    ST_D_RD,
    ST_D_EV,
    ST_T_RD,
    ST_T_EV,
    ST_W_POP,
    ST_W_RD,
    ST_W_EV,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: src/dlsq_ram.sv
`default_nettype none
module dlsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/delta_list_sleep_queue_unit.sv
`default_nettype none
// delta-list sleep queue: sleeping thread ids are kept in one ram in wake
// order, each entry holding its delay relative to the entry before it. a
// sequencer walks the ram entry by entry (read, then evaluate and write
// back through the single registered read port). a sleep request walks to
// its slot and shifts the tail up; a cancel searches and shifts the tail
// down; a tick reads the head and pops each woken entry with a shift. one
// transaction is worked on at a time; in_ready is high only between
// transactions, and results leave through an output register that holds
// them until out_ready. no result is produced for a tick that wakes nobody,
// a tick on an empty list or opcode 3.
module delta_list_sleep_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  thread_id,
  input  wire logic [31:0] duration,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [7:0]       thread_id_res,
  output logic             last
);
  import dlsq_pkg::*;

  // sequencer state
  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;     // live entries
  logic [CNT_W-1:0]  idx, idx_next;     // walk position
  logic [CNT_W-1:0]  pos, pos_next;     // insert / remove slot
  logic [31:0]       t, t_next;         // remaining delay on insert
  logic [31:0]       addv, addv_next;   // delta handed to the successor
  logic [1:0]        op, op_next;
  logic [7:0]        tid, tid_next;
  logic [WAKE_W-1:0] nwake, nwake_next;
  logic              cont, cont_next;   // emit then keep waking
  logic [2:0]        rkind, rkind_next;
  logic [7:0]        rtid, rtid_next;
  logic              rlast, rlast_next;

  // ram port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  dlsq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLEEPERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic out_load;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    logic [31:0] dd;
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    pos_next   = pos;
    t_next     = t;
    addv_next  = addv;
    op_next    = op;
    tid_next   = tid;
    nwake_next = nwake;
    cont_next  = cont;
    rkind_next = rkind;
    rtid_next  = rtid;
    rlast_next = rlast;
    ram_we     = 1'b0;
    ram_waddr  = idx[IDX_W-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = idx[IDX_W-1:0];
    out_load   = 1'b0;
    dd         = ram_rdata.delta;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_next    = opcode;
          tid_next   = thread_id;
          t_next     = duration;
          idx_next   = '0;
          cont_next  = 1'b0;
          rtid_next  = thread_id;
          rlast_next = 1'b1;
          unique case (opcode)
            OP_SLEEP: begin
              if (duration == 32'd0) begin
                rkind_next = KIND_BAD_DURATION;
                state_next = ST_EMIT;
              end else if (cnt == CNT_W'(MAX_SLEEPERS)) begin
                rkind_next = KIND_FULL;
                state_next = ST_EMIT;
              end else if (cnt == '0) begin
                pos_next   = '0;
                state_next = ST_INS;
              end else begin
                state_next = ST_S_RD;
              end
            end
            OP_CANCEL: begin
              if (cnt == '0) begin
                rkind_next = KIND_NOT_FOUND;
                state_next = ST_EMIT;
              end else begin
                state_next = ST_C_RD;
              end
            end
            OP_TICK: begin
              nwake_next = '0;
              if (cnt != '0) state_next = ST_T_RD;
            end
            default: ;
          endcase
        end
      end
      // insert walk: find the slot for the new entry
      ST_S_RD: begin
        state_next = ST_S_EV;
      end
      ST_S_EV: begin
        if ((idx == '0) ? (ram_rdata.delta > t) : (ram_rdata.delta >= t)) begin
          pos_next   = idx;
          idx_next   = cnt;
          state_next = ST_U_RD;
        end else begin
          t_next   = t - ram_rdata.delta;
          idx_next = idx + CNT_W'(1);
          if (idx + CNT_W'(1) == cnt) begin
            pos_next   = cnt;
            state_next = ST_INS;
          end else begin
            state_next = ST_S_RD;
          end
        end
      end
      // shift tail up from the top, successor loses the new delta
      ST_U_RD: begin
        ram_raddr  = IDX_W'(idx - CNT_W'(1));
        state_next = ST_U_EV;
      end
      ST_U_EV: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (idx - CNT_W'(1) == pos) ram_wdata.delta = ram_rdata.delta - t;
        idx_next = idx - CNT_W'(1);
        state_next = (idx - CNT_W'(1) == pos) ? ST_INS : ST_U_RD;
      end
      ST_INS: begin
        ram_we           = 1'b1;
        ram_waddr        = pos[IDX_W-1:0];
        ram_wdata.thread = tid;
        ram_wdata.delta  = t;
        cnt_next         = cnt + CNT_W'(1);
        rkind_next       = KIND_ACCEPTED;
        state_next       = ST_EMIT;
      end
      // cancel search
      ST_C_RD: begin
        state_next = ST_C_EV;
      end
      ST_C_EV: begin
        if (ram_rdata.thread == tid) begin
          pos_next  = idx;
          addv_next = ram_rdata.delta;
          if (idx + CNT_W'(1) < cnt) begin
            state_next = ST_D_RD;
          end else begin
            cnt_next   = cnt - CNT_W'(1);
            rkind_next = KIND_REMOVED;
            state_next = ST_EMIT;
          end
        end else begin
          idx_next = idx + CNT_W'(1);
          if (idx + CNT_W'(1) == cnt) begin
            rkind_next = KIND_NOT_FOUND;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_C_RD;
          end
        end
      end
      // shift tail down over the removed slot, successor gains its delta
      ST_D_RD: begin
        ram_raddr  = IDX_W'(idx + CNT_W'(1));
        state_next = ST_D_EV;
      end
      ST_D_EV: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (idx == pos) ram_wdata.delta = ram_rdata.delta + addv;
        if (idx + CNT_W'(2) == cnt) begin
          cnt_next = cnt - CNT_W'(1);
          if (op == OP_TICK) begin
            state_next = ST_W_RD;
          end else begin
            rkind_next = KIND_REMOVED;
            state_next = ST_EMIT;
          end
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ST_D_RD;
        end
      end
      // tick: decrement head, then wake due entries
      ST_T_RD: begin
        ram_raddr  = '0;
        state_next = ST_T_EV;
      end
      ST_T_EV: begin
        if (ram_rdata.delta != 32'd0) begin
          dd              = ram_rdata.delta - 32'd1;
          ram_we          = 1'b1;
          ram_waddr       = '0;
          ram_wdata.delta = dd;
        end
        if (dd == 32'd0) begin
          rtid_next  = ram_rdata.thread;
          nwake_next = WAKE_W'(1);
          state_next = ST_W_POP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_W_POP: begin
        if (cnt == CNT_W'(1)) begin
          cnt_next   = '0;
          rkind_next = KIND_WOKEN;
          rlast_next = 1'b1;
          cont_next  = 1'b0;
          state_next = ST_EMIT;
        end else begin
          pos_next   = '0;
          addv_next  = '0;
          idx_next   = '0;
          state_next = ST_D_RD;
        end
      end
      ST_W_RD: begin
        // keep the read port on the new head through evaluate and emit
        ram_raddr  = '0;
        idx_next   = '0;
        state_next = ST_W_EV;
      end
      ST_W_EV: begin
        // rtid holds the popped head until we know whether it is the last
        rkind_next = KIND_WOKEN;
        if (ram_rdata.delta == 32'd0 && nwake < WAKE_W'(MAX_RESULTS)) begin
          rlast_next = 1'b0;
          cont_next  = 1'b1;
        end else begin
          rlast_next = 1'b1;
          cont_next  = 1'b0;
        end
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (cont) begin
            rtid_next  = ram_rdata.thread;
            nwake_next = nwake + WAKE_W'(1);
            state_next = ST_W_POP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    idx   <= idx_next;
    pos   <= pos_next;
    t     <= t_next;
    addv  <= addv_next;
    op    <= op_next;
    tid   <= tid_next;
    nwake <= nwake_next;
    cont  <= cont_next;
    rkind <= rkind_next;
    rtid  <= rtid_next;
    rlast <= rlast_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      kind          <= rkind;
      thread_id_res <= rtid;
      last          <= rlast;
    end
  end

  // list never overfills
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_SLEEPERS))
    else $error("entry count above capacity");

  // count moves by one at most
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(cnt) |-> (cnt == $past(cnt) + CNT_W'(1) || cnt == $past(cnt) - CNT_W'(1)))
    else $error("entry count jumped");

  // writes stay inside the live list plus one
  a_waddr: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> CNT_W'(ram_waddr) <= cnt)
    else $error("ram write beyond list end");

  // no result is loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output overwritten");

endmodule
`default_nettype wire
